@@ sv/i2cmts_pkg.sv @@
// Shared types and constants for the I2C master transaction sequencer.
// Holds the word structs, status codes, transaction states and register map.
// No dependencies.
package i2cmts_pkg;

  localparam int DEF_BUF_DEPTH = 64;
  localparam int CFG_AW        = 4;
  localparam int CFG_DW        = 32;

  // function codes of an input word
  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_STATUS = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_LOAD   = 2'd3;

  // controller status codes
  localparam logic [7:0] SC_START        = 8'h08;
  localparam logic [7:0] SC_RSTART       = 8'h10;
  localparam logic [7:0] SC_ADDR_W_ACK   = 8'h18;
  localparam logic [7:0] SC_ADDR_W_NACK  = 8'h20;
  localparam logic [7:0] SC_DATA_W_ACK   = 8'h28;
  localparam logic [7:0] SC_DATA_W_NACK  = 8'h30;
  localparam logic [7:0] SC_ARB_LOST     = 8'h38;
  localparam logic [7:0] SC_ADDR_R_ACK   = 8'h40;
  localparam logic [7:0] SC_ADDR_R_NACK  = 8'h48;
  localparam logic [7:0] SC_DATA_R_ACK   = 8'h50;
  localparam logic [7:0] SC_DATA_R_NACK  = 8'h58;

  // transaction states
  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_BUSY      = 3'd1;
  localparam logic [2:0] ST_NO_DATA   = 3'd2;
  localparam logic [2:0] ST_OK        = 3'd3;
  localparam logic [2:0] ST_NACK_DATA = 3'd4;
  localparam logic [2:0] ST_NACK_ADDR = 3'd5;
  localparam logic [2:0] ST_ARB_LOST  = 3'd6;
  localparam logic [2:0] ST_TIMEOUT   = 3'd7;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_WRITE_LEN = 2'd0;
  localparam logic [1:0] REG_READ_LEN  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT   = 2'd2;

  localparam logic [23:0] TIMEOUT_RESET = 24'hFF_FFFF;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] status_code;
    logic [7:0] rx_byte;
    logic [5:0] load_index;
    logic [7:0] load_byte;
  } in_word_t;

  typedef struct packed {
    logic       set_start;
    logic       clear_start;
    logic       set_stop;
    logic       ack_next;
    logic       nack_next;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic [5:0] rx_position;
    logic [2:0] transaction_state;
  } out_word_t;

  typedef struct packed {
    logic [6:0]  write_length;
    logic [6:0]  read_length;
    logic [23:0] timeout_limit;
  } cfg_t;

endpackage

@@ sv/i2c_master_transaction_sequencer.sv @@
// Top level of the I2C master transaction sequencer.
// Depends on i2cmts_pkg, i2cmts_cfg_regs, i2cmts_wbuf and i2cmts_core.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------
//   in_      | in_valid/in_stall  | in_word  (i2cmts_pkg::in_word_t)
//   out_     | out_valid/out_stall| out_word (i2cmts_pkg::out_word_t)
//   cfg_     | APB psel/penable   | 32-bit registers at 0x0, 0x4, 0x8
//
// One word per cycle while out_stall is low: a word waits in the input register,
// is decoded in one pass, and its result sits in the output register.
// out_valid rises once the word has passed the input register and been decoded; a stall can hold it between.
// The write buffer read is prefetched from the next write position, so it adds no stall.
// rst_n clears the state and both stages; buffer contents are kept.
// A stalled result holds, and the input register can still take one more word.
module i2c_master_transaction_sequencer #(
  parameter int BUF_DEPTH = i2cmts_pkg::DEF_BUF_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  i2cmts_pkg::in_word_t            in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output i2cmts_pkg::out_word_t           out_word,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [i2cmts_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [i2cmts_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [i2cmts_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                            cfg_pready
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  i2cmts_pkg::cfg_t cfg;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [7:0]       rd_byte;
  logic [7:0]       byte0;

  i2cmts_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  i2cmts_wbuf #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_wbuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rd_byte (rd_byte),
    .byte0   (byte0)
  );

  i2cmts_core #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg       (cfg),
    .rd_byte   (rd_byte),
    .byte0     (byte0),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr)
  );

endmodule

@@ sv/i2cmts_cfg_regs.sv @@
// APB-style configuration registers of the sequencer.
// Depends on i2cmts_pkg for the register map and cfg_t.
module i2cmts_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [i2cmts_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [i2cmts_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [i2cmts_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                            cfg_pready,
  output i2cmts_pkg::cfg_t                cfg
);

  i2cmts_pkg::cfg_t cfg_r;
  logic             wr_en;
  logic [1:0]       reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[i2cmts_pkg::CFG_AW-1:2];
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.write_length  <= '0;
      cfg_r.read_length   <= '0;
      cfg_r.timeout_limit <= i2cmts_pkg::TIMEOUT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        i2cmts_pkg::REG_WRITE_LEN: cfg_r.write_length  <= cfg_pwdata[6:0];
        i2cmts_pkg::REG_READ_LEN:  cfg_r.read_length   <= cfg_pwdata[6:0];
        i2cmts_pkg::REG_TIMEOUT:   cfg_r.timeout_limit <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      i2cmts_pkg::REG_WRITE_LEN: cfg_prdata = {25'd0, cfg_r.write_length};
      i2cmts_pkg::REG_READ_LEN:  cfg_prdata = {25'd0, cfg_r.read_length};
      i2cmts_pkg::REG_TIMEOUT:   cfg_prdata = {8'd0, cfg_r.timeout_limit};
      default:                   cfg_prdata = '0;
    endcase
  end

endmodule

@@ sv/i2cmts_wbuf.sv @@
// Write buffer: byte memory with one write and one registered read port,
// a same-edge write bypass and a shadow copy of entry 0. Uses no package items.
module i2cmts_wbuf #(
  parameter int BUF_DEPTH = 64,
  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rd_byte,
  output logic [7:0]    byte0
);

  logic [7:0] mem [BUF_DEPTH];
  logic [7:0] rd_r;
  logic [7:0] byp_data_r;
  logic       byp_r;
  logic [7:0] byte0_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r       <= mem[raddr];
    byp_data_r <= wdata;
    if (we && (waddr == '0)) begin
      byte0_r <= wdata;
    end
  end

  // a write landing on the address being read wins over the stale read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= we && (waddr == raddr);
    end
  end

  assign rd_byte = byp_r ? byp_data_r : rd_r;
  assign byte0   = byte0_r;

endmodule

@@ sv/i2cmts_core.sv @@
// Sequencer core: input register, transaction state and decode of one word,
// result register. Depends on i2cmts_pkg; reads the write buffer via i2cmts_wbuf.
module i2cmts_core #(
  parameter int BUF_DEPTH = 64,
  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1,
  localparam int PW = $clog2(BUF_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  i2cmts_pkg::in_word_t   in_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output i2cmts_pkg::out_word_t  out_word,
  input  i2cmts_pkg::cfg_t       cfg,
  input  logic [7:0]             rd_byte,
  input  logic [7:0]             byte0,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_waddr,
  output logic [7:0]             mem_wdata,
  output logic [AW-1:0]          mem_raddr
);

  localparam int CW = ((PW > 7) ? PW : 7) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(BUF_DEPTH);

  logic                  in_vld_r;
  i2cmts_pkg::in_word_t  in_word_r;
  logic                  out_vld_r;
  i2cmts_pkg::out_word_t out_word_r;
  logic                  advance;
  logic                  accept;
  logic                  process;

  logic [PW-1:0]         wpos_r,  wpos_nxt;
  logic [PW-1:0]         rpos_r,  rpos_nxt;
  logic [23:0]           tick_r,  tick_nxt;
  logic [2:0]            st_r,    st_nxt;
  i2cmts_pkg::out_word_t out_nxt;

  logic                  wpos_room;
  logic                  rpos_room;
  logic [PW-1:0]         wpos_inc;
  logic [PW-1:0]         rpos_inc;

  assign advance  = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !advance;
  assign accept   = in_valid && !in_stall;
  assign process  = in_vld_r && advance;

  assign wpos_room = CW'(wpos_r) < DEPTH_C;
  assign rpos_room = CW'(rpos_r) < DEPTH_C;
  assign wpos_inc  = wpos_room ? PW'(wpos_r + 1'b1) : wpos_r;
  assign rpos_inc  = PW'(rpos_r + 1'b1);

  always_comb begin
    logic do_ack;
    logic send;
    logic send_first;
    do_ack     = 1'b0;
    send       = 1'b0;
    send_first = 1'b0;
    out_nxt    = '0;
    wpos_nxt   = wpos_r;
    rpos_nxt   = rpos_r;
    tick_nxt   = tick_r;
    st_nxt     = st_r;

    if (process) begin
      case (in_word_r.func)
        i2cmts_pkg::FUNC_START: begin
          wpos_nxt          = '0;
          rpos_nxt          = '0;
          tick_nxt          = '0;
          st_nxt            = i2cmts_pkg::ST_BUSY;
          out_nxt.set_start = 1'b1;
        end
        i2cmts_pkg::FUNC_STATUS: begin
          tick_nxt = '0;
          unique case (in_word_r.status_code) inside
            i2cmts_pkg::SC_START: begin
              send_first          = 1'b1;
              out_nxt.clear_start = 1'b1;
            end
            i2cmts_pkg::SC_RSTART: begin
              rpos_nxt            = '0;
              send                = 1'b1;
              out_nxt.clear_start = 1'b1;
            end
            i2cmts_pkg::SC_ADDR_W_ACK: begin
              if (cfg.write_length == 7'd1) begin
                out_nxt.set_stop = 1'b1;
                st_nxt           = i2cmts_pkg::ST_NO_DATA;
              end else begin
                send = 1'b1;
              end
            end
            i2cmts_pkg::SC_DATA_W_ACK: begin
              if (CW'(wpos_r) < CW'(cfg.write_length)) begin
                send = 1'b1;
              end else if (cfg.read_length != '0) begin
                out_nxt.set_start = 1'b1;
              end else begin
                out_nxt.set_stop = 1'b1;
                st_nxt           = i2cmts_pkg::ST_OK;
              end
            end
            i2cmts_pkg::SC_DATA_W_NACK: begin
              out_nxt.set_stop = 1'b1;
              st_nxt           = i2cmts_pkg::ST_NACK_DATA;
            end
            i2cmts_pkg::SC_ADDR_R_ACK: begin
              do_ack = 1'b1;
            end
            i2cmts_pkg::SC_DATA_R_ACK: begin
              if (rpos_room) begin
                out_nxt.rx_valid    = 1'b1;
                out_nxt.rx_data     = in_word_r.rx_byte;
                out_nxt.rx_position = 6'(rpos_r);
                rpos_nxt            = rpos_inc;
              end
              do_ack = 1'b1;
            end
            i2cmts_pkg::SC_DATA_R_NACK: begin
              if (rpos_room) begin
                out_nxt.rx_valid    = 1'b1;
                out_nxt.rx_data     = in_word_r.rx_byte;
                out_nxt.rx_position = 6'(rpos_r);
                rpos_nxt            = rpos_inc;
              end
              out_nxt.set_stop = 1'b1;
              st_nxt           = i2cmts_pkg::ST_OK;
            end
            i2cmts_pkg::SC_ADDR_W_NACK, i2cmts_pkg::SC_ADDR_R_NACK: begin
              out_nxt.set_stop = 1'b1;
              st_nxt           = i2cmts_pkg::ST_NACK_ADDR;
            end
            default: begin
              st_nxt = i2cmts_pkg::ST_ARB_LOST;
            end
          endcase
        end
        i2cmts_pkg::FUNC_TICK: begin
          if (st_r == i2cmts_pkg::ST_BUSY) begin
            if (tick_r >= cfg.timeout_limit) begin
              st_nxt = i2cmts_pkg::ST_TIMEOUT;
            end else begin
              tick_nxt = tick_r + 24'd1;
            end
          end
        end
        default: ;
      endcase

      // restart from entry 0; the shadow copy saves a second read port
      if (send_first) begin
        out_nxt.tx_valid = 1'b1;
        out_nxt.tx_byte  = byte0;
        wpos_nxt         = PW'(1);
      end
      if (send) begin
        out_nxt.tx_valid = 1'b1;
        out_nxt.tx_byte  = wpos_room ? rd_byte : 8'd0;
        wpos_nxt         = wpos_inc;
      end
      // decide on the read position after this byte is taken
      if (do_ack) begin
        if ((CW'(rpos_nxt) + CW'(1)) < CW'(cfg.read_length)) begin
          out_nxt.ack_next = 1'b1;
        end else begin
          out_nxt.nack_next = 1'b1;
        end
      end

      if ((st_r == i2cmts_pkg::ST_BUSY) && (st_nxt != i2cmts_pkg::ST_BUSY)) begin
        out_nxt.clear_start = 1'b1;
      end
      out_nxt.transaction_state = st_nxt;
    end
  end

  // buffer ports: prefetch the entry the next word will send
  assign mem_we    = process && (in_word_r.func == i2cmts_pkg::FUNC_LOAD)
                     && (CW'(in_word_r.load_index) < DEPTH_C);
  assign mem_waddr = AW'(in_word_r.load_index);
  assign mem_wdata = in_word_r.load_byte;
  assign mem_raddr = (CW'(wpos_nxt) < DEPTH_C) ? AW'(wpos_nxt) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      wpos_r    <= '0;
      rpos_r    <= '0;
      tick_r    <= '0;
      st_r      <= i2cmts_pkg::ST_IDLE;
    end else begin
      if (accept) begin
        in_vld_r <= 1'b1;
      end else if (process) begin
        in_vld_r <= 1'b0;
      end
      if (process) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      wpos_r <= wpos_nxt;
      rpos_r <= rpos_nxt;
      tick_r <= tick_nxt;
      st_r   <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_word_r <= in_word;
    end
    if (process) begin
      out_word_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

endmodule
